/* src/assert_macros.svh */
// Assertion macros used by the checker module smset_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/smset_pkg.sv */
// Package for the sorted mark set: sizes, operation codes, item and cell types.
// No dependencies.
`timescale 1ns / 1ps

package smset_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] identifier;
  } smset_in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
    logic             full_drop;
  } smset_out_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic            shift_en;
    logic [ID_W-1:0] id;
  } smset_ctl_t;

  // Compare status from one cell.
  typedef struct packed {
    logic lt;
    logic eq;
  } smset_stat_t;

endpackage

/* src/smset_cell.sv */
// One cell of the sorted chain: holds an entry, compares it, shifts on insert.
// Depends on smset_pkg.
`timescale 1ns / 1ps

module smset_cell (
  input  logic                          clk_i,
  input  smset_pkg::smset_ctl_t         ctl_i,
  input  logic                          active_i,
  input  logic                          prev_lt_i,
  input  logic [smset_pkg::ID_W-1:0]    prev_entry_i,
  output logic [smset_pkg::ID_W-1:0]    entry_o,
  output smset_pkg::smset_stat_t        stat_o
);
  import smset_pkg::*;

  logic [ID_W-1:0] entry_q;

  assign entry_o   = entry_q;
  assign stat_o.lt = active_i && (entry_q < ctl_i.id);
  assign stat_o.eq = active_i && (entry_q == ctl_i.id);

  // Cells at and above the insertion point move up; the boundary cell takes the new id.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_en && !stat_o.lt) begin
      entry_q <= prev_lt_i ? ctl_i.id : prev_entry_i;
    end
  end

endmodule

/* src/sorted_mark_set_top.sv */
// Top level of the sorted mark set: cell chain, count, limit register, result buffer.
// Depends on smset_pkg and smset_cell.
`timescale 1ns / 1ps

// Sorted mark set. Keeps up to CAPACITY distinct identifiers in ascending order
// in a chain of cells. Each item is clear, mark or query and gives one result
// item. For each item every cell compares its entry with the
// identifier in parallel, the count and position follow from those compares,
// and on a mark the cell at the insertion point takes the identifier and each
// cell past it takes its lower neighbor's entry at the same clock edge. The
// result is registered into a two-entry result buffer, so one item per cycle
// is taken as long as results are drained. Identifiers above the limit
// register max_q are never marked and are reported absent; a mark of a new
// identifier on a full set is dropped and flagged with full_drop.
module sorted_mark_set_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  smset_pkg::smset_in_t        in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output smset_pkg::smset_out_t       out_data_o,
  input  logic                        cfg_we_i,
  input  logic [smset_pkg::ID_W-1:0]  cfg_wdata_i
);
  import smset_pkg::*;

  logic [ID_W-1:0]  max_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic [ID_W-1:0]  entries [CAPACITY];
  smset_stat_t      stats   [CAPACITY];
  logic [CAPACITY:0] lt;
  logic [CAPACITY-1:0] eq;
  smset_ctl_t       ctl;

  logic             accept;
  logic             hit;
  logic             in_range;
  logic             ins;
  logic [CNT_W-1:0] pos;
  smset_out_t       res;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = in_data_i.identifier <= max_q;
  assign hit      = |eq;

  assign ctl.id       = in_data_i.identifier;
  assign ctl.shift_en = ins && accept;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic             active;
    logic             prev_lt;
    logic [ID_W-1:0]  prev_entry;

    assign active = CNT_W'(k) < count_q;
    if (k == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = '0;
    end else begin : g_rest
      assign prev_lt    = lt[k-1];
      assign prev_entry = entries[k-1];
    end

    smset_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .active_i     (active),
      .prev_lt_i    (prev_lt),
      .prev_entry_i (prev_entry),
      .entry_o      (entries[k]),
      .stat_o       (stats[k])
    );

    assign lt[k] = stats[k].lt;
    assign eq[k] = stats[k].eq;
  end
  assign lt[CAPACITY] = 1'b0;

  // lt is a prefix of ones; the position is the end of that prefix.
  always_comb begin
    pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (lt[k] && !lt[k+1]) begin
        pos = pos | CNT_W'(k + 1);
      end
    end
  end

  always_comb begin
    res     = '0;
    ins     = 1'b0;
    count_d = count_q;
    case (in_data_i.operation)
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_MARK, OP_QUERY: begin
        res.position = pos;
        res.found    = hit && in_range;
        if (in_data_i.operation == OP_MARK && in_range && !hit) begin
          if (count_q == CNT_W'(CAPACITY)) begin
            res.full_drop = 1'b1;
          end else begin
            ins     = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    res.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '1;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Two-entry result buffer: head drives the port, tail catches one more item.
  logic       head_v_q, head_v_d;
  logic       tail_v_q, tail_v_d;
  smset_out_t head_q, tail_q;
  logic       pop;
  logic       head_load, head_from_tail, tail_load;

  assign pop         = head_v_q && out_ready_i;
  assign in_ready_o  = !tail_v_q;
  assign out_valid_o = head_v_q;
  assign out_data_o  = head_q;

  always_comb begin
    head_v_d       = head_v_q;
    tail_v_d       = tail_v_q;
    head_load      = 1'b0;
    head_from_tail = 1'b0;
    tail_load      = 1'b0;
    case ({accept, pop})
      2'b10: begin
        if (!head_v_q) begin
          head_load = 1'b1;
          head_v_d  = 1'b1;
        end else begin
          tail_load = 1'b1;
          tail_v_d  = 1'b1;
        end
      end
      2'b01: begin
        if (tail_v_q) begin
          head_from_tail = 1'b1;
          tail_v_d       = 1'b0;
        end else begin
          head_v_d = 1'b0;
        end
      end
      2'b11: begin
        if (tail_v_q) begin
          head_from_tail = 1'b1;
          tail_load      = 1'b1;
        end else begin
          head_load = 1'b1;
        end
      end
      default: begin
        head_v_d = head_v_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      tail_v_q <= tail_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_from_tail) begin
      head_q <= tail_q;
    end else if (head_load) begin
      head_q <= res;
    end
    if (tail_load) begin
      tail_q <= res;
    end
  end

endmodule

/* src/smset_checker.sv */
// Port-level checks for the sorted mark set, bound to the top level.
// Depends on smset_pkg, assert_macros.svh and sorted_mark_set_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smset_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  smset_pkg::smset_out_t       out_data_o
);
  import smset_pkg::*;

  logic in_acc;
  logic out_stall;
  logic pos_ok;
  logic found_ok;
  logic drop_ok;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign pos_ok    = out_data_o.position <= out_data_o.entry_count;
  assign found_ok  = (out_data_o.position < out_data_o.entry_count) && !out_data_o.full_drop;
  assign drop_ok   = (out_data_o.entry_count == CNT_W'(CAPACITY)) && !out_data_o.found;

  `SMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  `SMS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_valid_o)

  `SMS_ASSERT_NOW(a_pos_bound, clk_i, rst_ni, out_valid_o, pos_ok)

  `SMS_ASSERT_NOW(a_found_pos, clk_i, rst_ni, out_valid_o && out_data_o.found, found_ok)

  `SMS_ASSERT_NOW(a_drop_full, clk_i, rst_ni, out_valid_o && out_data_o.full_drop, drop_ok)

endmodule

bind sorted_mark_set_top smset_checker u_smset_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
